>>> rtl/mtspt_pkg.sv
// package for the multitouch slot pointer tracker
// shared types, codes and the default slot count; no dependencies
package mtspt_pkg;

  localparam int unsigned SlotsDef = 10;

  localparam logic [1:0] OpEvent = 2'd0;
  localparam logic [1:0] OpPoll  = 2'd1;
  localparam logic [1:0] OpLost  = 2'd2;

  localparam logic [15:0] EvKey = 16'd1;
  localparam logic [15:0] EvRel = 16'd2;
  localparam logic [15:0] EvAbs = 16'd3;

  localparam logic [15:0] CodeX      = 16'h0000;
  localparam logic [15:0] CodeY      = 16'h0001;
  localparam logic [15:0] CodeSlot   = 16'h002f;
  localparam logic [15:0] CodeMtX    = 16'h0035;
  localparam logic [15:0] CodeMtY    = 16'h0036;
  localparam logic [15:0] CodeTrack  = 16'h0039;
  localparam logic [15:0] CodeBtnMse = 16'h0110;
  localparam logic [15:0] CodeBtnTch = 16'h014a;

  localparam logic [2:0] CfgSwap = 3'd0;
  localparam logic [2:0] CfgCal  = 3'd1;
  localparam logic [2:0] CfgXMin = 3'd2;
  localparam logic [2:0] CfgXMax = 3'd3;
  localparam logic [2:0] CfgYMin = 3'd4;
  localparam logic [2:0] CfgYMax = 3'd5;
  localparam logic [2:0] CfgW    = 3'd6;
  localparam logic [2:0] CfgH    = 3'd7;

  // datapath command from controller
  typedef enum logic [3:0] {
    CmdNone,
    CmdEvent,
    CmdLost,
    CmdSumClr,
    CmdSumAcc,
    CmdDivInit,
    CmdDivStep,
    CmdResolve,
    CmdMapInit,
    CmdMapMul,
    CmdOut
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       axis_y;
  } dp_cmd_t;

  typedef struct packed {
    logic mt_pending;
    logic slot_last;
    logic div_done;
    logic cal_en;
  } dp_stat_t;

endpackage

>>> rtl/mtspt_div.sv
// restoring divider, one quotient bit per cycle, signed truncating result
// depends on mtspt_pkg for nothing but house style
module mtspt_div import mtspt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] num_i,
  input  logic signed [17:0] den_i,
  output logic               done_o,
  output logic signed [47:0] quo_o
);

  logic [47:0] n_q, n_d, q_q, q_d;
  logic [17:0] dmag_q, dmag_d;
  logic [48:0] r_q, r_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [48:0] sh;

  always_comb begin
    n_d = n_q; q_d = q_q; dmag_d = dmag_q; r_d = r_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q;
    sh = '0;
    if (start_i) begin
      n_d    = num_i[47] ? 48'(-num_i) : num_i;
      dmag_d = den_i[17] ? 18'(-den_i) : den_i;
      neg_d  = num_i[47] ^ den_i[17];
      r_d    = '0;
      q_d    = '0;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh = {r_q[47:0], n_q[47]};
      n_d = {n_q[46:0], 1'b0};
      if (sh >= {31'd0, dmag_q}) begin
        r_d = sh - {31'd0, dmag_q};
        q_d = {q_q[46:0], 1'b1};
      end else begin
        r_d = sh;
        q_d = {q_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; q_q <= q_d; dmag_q <= dmag_d; r_q <= r_d; neg_q <= neg_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quo_o  = neg_q ? 48'(-q_q) : q_q;

endmodule

>>> rtl/mtspt_datapath.sv
// datapath: slot table, pointer state, centroid sum, mapping and clamp
// depends on mtspt_pkg and mtspt_div
module mtspt_datapath import mtspt_pkg::*; #(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [1:0]  op_i,
  input  logic [15:0] ev_type_i,
  input  logic [15:0] ev_code_i,
  input  logic [31:0] ev_value_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output dp_stat_t    stat_o,
  output logic [11:0] x_pos_o,
  output logic [11:0] y_pos_o,
  output logic        pressed_o,
  output logic [3:0]  touch_count_o
);

  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);

  logic [31:0] slot_x_q [Slots];
  logic [31:0] slot_y_q [Slots];
  logic [2:0]  flags_q  [Slots];
  logic [SW-1:0] cur_q, idx_q;
  logic [31:0] px_q, py_q;
  logic        btn_q, cancel_q, pend_q;
  logic [3:0]  touches_q;
  logic        swap_q, cal_q;
  logic [15:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic [12:0] w_q, h_q;
  logic signed [35:0] xs_q, ys_q;
  logic [CW-1:0] n_q;
  logic signed [31:0] cx_q;
  logic signed [47:0] prod_q, mx_q, my_q;
  logic        div_start;
  logic signed [47:0] div_num;
  logic signed [17:0] div_den;
  logic        div_done;
  logic signed [47:0] div_quo;
  logic [11:0] xo_q, yo_q;
  logic        pr_q;

  // effective resolution
  function automatic logic [12:0] eff(input logic [12:0] r);
    if (r == 13'd0) return 13'd1;
    if (r > 13'd4096) return 13'd4096;
    return r;
  endfunction

  function automatic logic [11:0] clampf(input logic signed [47:0] v,
                                         input logic [12:0] r);
    if (v < 0) return 12'd0;
    if (v >= $signed({35'd0, r})) return 12'(r - 13'd1);
    return v[11:0];
  endfunction

  logic signed [31:0] sv;
  logic [SW-1:0] s;
  logic to_x;
  logic [12:0] we, he;
  logic signed [16:0] amin, amax;
  logic [15:0] lo, hi;
  logic signed [47:0] mval;

  assign sv = ev_value_i;
  assign s  = (32'(cur_q) >= Slots) ? '0 : cur_q;
  assign to_x = swap_q ? ev_code_i[0] : !ev_code_i[0];
  assign we = eff(w_q);
  assign he = eff(h_q);
  assign lo = cmd_i.axis_y ? ymin_q : xmin_q;
  assign hi = cmd_i.axis_y ? ymax_q : xmax_q;
  assign amin = 17'(signed'(lo));
  assign amax = 17'(signed'(hi));

  assign div_start = (cmd_i.cmd == CmdDivInit) || (cmd_i.cmd == CmdMapMul);
  assign div_num = (cmd_i.cmd == CmdDivInit) ?
                   (cmd_i.axis_y ? 48'(ys_q) : 48'(xs_q)) : prod_q;
  assign div_den = (cmd_i.cmd == CmdDivInit) ? 18'(signed'({1'b0, n_q})) :
                   18'(amax - amin);

  mtspt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign mval = cmd_i.axis_y ? 48'(signed'(py_q)) : 48'(signed'(px_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        slot_x_q[i] <= '0;
        slot_y_q[i] <= '0;
        flags_q[i]  <= '0;
      end
      cur_q <= '0; idx_q <= '0; px_q <= '0; py_q <= '0;
      btn_q <= 1'b0; cancel_q <= 1'b0; pend_q <= 1'b0; touches_q <= '0;
      swap_q <= 1'b0; cal_q <= 1'b0;
      xmin_q <= '0; xmax_q <= 16'd4095; ymin_q <= '0; ymax_q <= 16'd4095;
      w_q <= 13'd800; h_q <= 13'd480;
      xs_q <= '0; ys_q <= '0; n_q <= '0; cx_q <= '0;
      prod_q <= '0; mx_q <= '0; my_q <= '0;
      xo_q <= '0; yo_q <= '0; pr_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSwap: swap_q <= cfg_data_i[0];
          CfgCal:  cal_q  <= cfg_data_i[0];
          CfgXMin: xmin_q <= cfg_data_i[15:0];
          CfgXMax: xmax_q <= cfg_data_i[15:0];
          CfgYMin: ymin_q <= cfg_data_i[15:0];
          CfgYMax: ymax_q <= cfg_data_i[15:0];
          CfgW:    w_q    <= cfg_data_i[12:0];
          CfgH:    h_q    <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      case (cmd_i.cmd)
        CmdEvent: begin
          if (op_i == OpEvent) begin
            if (ev_type_i == EvRel && (ev_code_i == CodeX || ev_code_i == CodeY)) begin
              if (to_x) px_q <= px_q + ev_value_i;
              else      py_q <= py_q + ev_value_i;
            end else if (ev_type_i == EvAbs) begin
              if (ev_code_i == CodeX || ev_code_i == CodeY) begin
                if (to_x) px_q <= ev_value_i;
                else      py_q <= ev_value_i;
              end else if (ev_code_i == CodeSlot) begin
                if (sv >= 0 && sv < $signed(32'(Slots))) cur_q <= SW'(sv);
                pend_q <= 1'b1;
              end else if (ev_code_i == CodeMtX) begin
                slot_x_q[s] <= ev_value_i;
                flags_q[s]  <= flags_q[s] | 3'b010;
                pend_q <= 1'b1;
              end else if (ev_code_i == CodeMtY) begin
                slot_y_q[s] <= ev_value_i;
                flags_q[s]  <= flags_q[s] | 3'b100;
                pend_q <= 1'b1;
              end else if (ev_code_i == CodeTrack) begin
                flags_q[s] <= (sv >= 0) ? (flags_q[s] | 3'b001) : 3'b000;
                pend_q <= 1'b1;
              end
            end else if (ev_type_i == EvKey &&
                         (ev_code_i == CodeBtnMse || ev_code_i == CodeBtnTch)) begin
              if (sv == 0) begin
                btn_q <= 1'b0; touches_q <= '0; cancel_q <= 1'b0;
              end else if (sv == 1) begin
                btn_q <= 1'b1;
                if (touches_q == '0) touches_q <= 4'd1;
              end
            end
          end
        end
        CmdLost: cancel_q <= 1'b1;
        CmdSumClr: begin
          xs_q <= '0; ys_q <= '0; n_q <= '0; idx_q <= '0;
        end
        CmdSumAcc: begin
          if (flags_q[idx_q] == 3'b111) begin
            xs_q <= xs_q + 36'(signed'(slot_x_q[idx_q]));
            ys_q <= ys_q + 36'(signed'(slot_y_q[idx_q]));
            n_q  <= n_q + CW'(1);
          end
          idx_q <= idx_q + SW'(1);
        end
        CmdDivStep: begin
          if (div_done && !cmd_i.axis_y) cx_q <= div_quo[31:0];
        end
        CmdResolve: begin
          touches_q <= (32'(n_q) > 15) ? 4'd15 : 4'(n_q);
          if (n_q != '0) begin
            px_q <= swap_q ? div_quo[31:0] : cx_q;
            py_q <= swap_q ? cx_q : div_quo[31:0];
            btn_q <= 1'b1;
          end else begin
            btn_q <= 1'b0; cancel_q <= 1'b0;
          end
          pend_q <= 1'b0;
        end
        CmdMapInit: begin
          prod_q <= (mval - 48'(amin)) * 48'(signed'({1'b0, cmd_i.axis_y ? he : we}));
        end
        CmdMapMul: ;
        CmdOut: begin
          if (cal_q) begin
            xo_q <= clampf((xmin_q == xmax_q) ? 48'sd0 : mx_q, we);
            yo_q <= clampf((ymin_q == ymax_q) ? 48'sd0 : my_q, he);
          end else begin
            xo_q <= clampf(48'(signed'(px_q)), we);
            yo_q <= clampf(48'(signed'(py_q)), he);
          end
          pr_q <= cancel_q ? 1'b0 : btn_q;
          if (cancel_q && !btn_q) cancel_q <= 1'b0;
        end
        default: ;
      endcase
      if (cmd_i.cmd == CmdDivStep && div_done && cal_q && !pend_q) begin
        if (cmd_i.axis_y) my_q <= div_quo;
        else              mx_q <= div_quo;
      end
    end
  end

  assign stat_o.mt_pending = pend_q;
  assign stat_o.slot_last  = (32'(idx_q) == Slots - 1);
  assign stat_o.div_done   = div_done;
  assign stat_o.cal_en     = cal_q;
  assign x_pos_o       = xo_q;
  assign y_pos_o       = yo_q;
  assign pressed_o     = pr_q;
  assign touch_count_o = touches_q;

endmodule

>>> rtl/mtspt_ctrl.sv
// controller: sequences events, centroid resolve, mapping and output
// depends on mtspt_pkg
module mtspt_ctrl import mtspt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] op_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    SIdle, SSum, SDivXI, SDivX, SDivYI, SDivY, SRes,
    SMapXI, SMapXM, SMapX, SMapYI, SMapYM, SMapY, SOut, SHold
  } state_e;

  state_e st_q;
  logic   vld_q;

  assign in_ready_o  = (st_q == SIdle) && !vld_q;
  assign out_valid_o = vld_q;

  always_comb begin
    cmd_o = '{cmd: CmdNone, axis_y: 1'b0};
    case (st_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (op_i == OpEvent)      cmd_o.cmd = CmdEvent;
          else if (op_i == OpLost)  cmd_o.cmd = CmdLost;
          else if (op_i == OpPoll)  cmd_o.cmd = CmdSumClr;
        end
      end
      SSum:   cmd_o.cmd = CmdSumAcc;
      SDivXI: cmd_o.cmd = CmdDivInit;
      SDivX:  cmd_o.cmd = CmdDivStep;
      SDivYI: cmd_o = '{cmd: CmdDivInit, axis_y: 1'b1};
      SDivY:  cmd_o = '{cmd: CmdDivStep, axis_y: 1'b1};
      SRes:   cmd_o = '{cmd: CmdResolve, axis_y: 1'b1};
      SMapXI: cmd_o.cmd = CmdMapInit;
      SMapXM: cmd_o.cmd = CmdMapMul;
      SMapX:  cmd_o.cmd = CmdDivStep;
      SMapYI: cmd_o = '{cmd: CmdMapInit, axis_y: 1'b1};
      SMapYM: cmd_o = '{cmd: CmdMapMul, axis_y: 1'b1};
      SMapY:  cmd_o = '{cmd: CmdDivStep, axis_y: 1'b1};
      SOut:   cmd_o.cmd = CmdOut;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= SIdle;
      vld_q <= 1'b0;
    end else begin
      if (vld_q && out_ready_i) vld_q <= 1'b0;
      case (st_q)
        SIdle: begin
          if (in_valid_i && in_ready_o && op_i == OpPoll) begin
            st_q <= stat_i.mt_pending ? SSum : (stat_i.cal_en ? SMapXI : SOut);
          end
        end
        SSum:   if (stat_i.slot_last) st_q <= SDivXI;
        SDivXI: st_q <= SDivX;
        SDivX:  if (stat_i.div_done) st_q <= SDivYI;
        SDivYI: st_q <= SDivY;
        SDivY:  if (stat_i.div_done) st_q <= SRes;
        SRes:   st_q <= stat_i.cal_en ? SMapXI : SOut;
        SMapXI: st_q <= SMapXM;
        SMapXM: st_q <= SMapX;
        SMapX:  if (stat_i.div_done) st_q <= SMapYI;
        SMapYI: st_q <= SMapYM;
        SMapYM: st_q <= SMapY;
        SMapY:  if (stat_i.div_done) st_q <= SOut;
        SOut: begin
          st_q  <= SIdle;
          vld_q <= 1'b1;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

endmodule

>>> rtl/multitouch_slot_pointer_tracker.sv
// top level of the multitouch slot pointer tracker
// depends on mtspt_pkg, mtspt_ctrl, mtspt_datapath, mtspt_div
//
// channel   dir  fields
// s_axis    in   tdata: op, ev_type, ev_code, ev_value
// m_axis    out  tdata: x_pos, y_pos, pressed, touch_count
// cfg       in   cfg_index_i, cfg_data_i
//
// events and press-lost words are applied as they are accepted and give no
// result; a poll runs centroid and calibration divides on the shared 48-step
// divider as needed, then outputs. one word in flight; the next word waits
// until the result is taken. reset restores all state but divider data regs.
module multitouch_slot_pointer_tracker import mtspt_pkg::*; #(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // op, ev_type, ev_code, ev_value, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // x_pos, y_pos, pressed, touch_count, pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [11:0] xp, yp;
  logic        pr;
  logic [3:0]  tc;

  assign cfg_ready_o = 1'b1;

  mtspt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .op_i        (s_axis_tdata[1:0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mtspt_datapath #(.Slots(Slots)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (s_axis_tdata[1:0]),
    .ev_type_i     (s_axis_tdata[17:2]),
    .ev_code_i     (s_axis_tdata[33:18]),
    .ev_value_i    (s_axis_tdata[65:34]),
    .cfg_we_i      (cfg_valid_i),
    .cfg_idx_i     (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .stat_o        (stat),
    .x_pos_o       (xp),
    .y_pos_o       (yp),
    .pressed_o     (pr),
    .touch_count_o (tc)
  );

  assign m_axis_tdata = {3'd0, tc, pr, yp, xp};

endmodule
